// ----- rtl/core/bgb_pkg.sv -----
// Package: shared types and constants for the bitmap glyph blitter.
`timescale 1ns / 1ps
package bgb_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_SIZE      = 8;
  localparam int ROW_PIXELS      = 8;

  localparam int CODE_W   = 7;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int BITS_W   = 8;
  localparam int COORD_W  = 11;
  localparam int STRIDE_W = 11;
  localparam int COLOR_W  = 24;
  localparam int ADDR_W   = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd640;
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'hFF0000;
  localparam logic [COL_W-1:0]    COL_LAST     = 3'd7;
  localparam logic [ROW_W-1:0]    ROW_LAST     = 3'd7;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_STRIDE  = 1'b0,
    CFG_PIXEL_COLOR = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_FLUSH
  } seq_state_t;

  // Control from the sequencer to the address unit
  typedef struct packed {
    logic load;     // take a new base address from the origin
    logic step;     // advance by one pixel
    logic row_end;  // step wraps to the start of the next glyph row
  } addr_ctrl_t;

endpackage

// ----- rtl/core/bgb_glyph_mem.sv -----
// Glyph row store: one write port, one registered read port.
`timescale 1ns / 1ps
module bgb_glyph_mem
  import bgb_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [$clog2(GLYPH_COUNT*GLYPH_SIZE)-1:0]    wr_addr,
  input  logic [BITS_W-1:0]                            wr_data,
  input  logic [$clog2(GLYPH_COUNT*GLYPH_SIZE)-1:0]    rd_addr,
  output logic [BITS_W-1:0]                            rd_data
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_SIZE;

  logic [BITS_W-1:0] mem [DEPTH];
  logic [BITS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/bgb_addr_unit.sv -----
// Pixel address unit: base multiply, then one shared adder stepping per pixel.
`timescale 1ns / 1ps
module bgb_addr_unit
  import bgb_pkg::*;
(
  input  logic                clk,
  input  addr_ctrl_t          ctrl,
  input  logic [COORD_W-1:0]  x_origin,
  input  logic [COORD_W-1:0]  y_origin,
  input  logic [STRIDE_W-1:0] row_stride,
  output logic [ADDR_W-1:0]   pixel_address
);

  logic [ADDR_W-1:0]             addr_r;
  logic [ADDR_W-1:0]             addr_nxt;
  logic [ADDR_W-1:0]             wrap_r;
  logic [COORD_W+STRIDE_W-1:0]   line_base;
  logic [ADDR_W-1:0]             operand;

  assign line_base = y_origin * row_stride;
  // step of one pixel, or from column 7 back to column 0 of the next line
  assign operand   = ctrl.row_end ? wrap_r : ADDR_W'(1);

  always_comb begin
    addr_nxt = addr_r;
    if (ctrl.load) begin
      addr_nxt = ADDR_W'(line_base) + ADDR_W'(x_origin);
    end else if (ctrl.step) begin
      addr_nxt = addr_r + operand;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (ctrl.load) begin
      wrap_r <= ADDR_W'(row_stride) - ADDR_W'(ROW_PIXELS - 1);
    end
  end

  assign pixel_address = addr_r;

endmodule

// ----- rtl/core/bgb_seq.sv -----
// Draw sequencer: row/column scan, pending-pixel hold and result register.
`timescale 1ns / 1ps
module bgb_seq
  import bgb_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      draw_go,
  input  logic [CODE_W-1:0]                         in_char_code,
  input  logic [BITS_W-1:0]                         rd_data,
  input  logic [ADDR_W-1:0]                         cur_address,
  input  logic [COLOR_W-1:0]                        pixel_color,
  output logic [$clog2(GLYPH_COUNT*GLYPH_SIZE)-1:0] rd_addr,
  output addr_ctrl_t                                ctrl,
  output logic                                      busy,
  output logic                                      out_strobe,
  output logic [ADDR_W-1:0]                         out_pixel_address,
  output logic [COLOR_W-1:0]                        out_pixel_value,
  output logic                                      out_last_write
);

  localparam int AW = $clog2(GLYPH_COUNT * GLYPH_SIZE);

  seq_state_t         state_r, state_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [BITS_W-1:0]  line_r, line_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic               strobe_r, strobe_nxt;
  logic [ADDR_W-1:0]  oaddr_r, oaddr_nxt;
  logic [COLOR_W-1:0] ovalue_r, ovalue_nxt;
  logic               olast_r, olast_nxt;
  logic [ROW_W-1:0]   rd_row;
  logic               pix_set;

  assign pix_set = line_r[col_r];
  assign rd_row  = row_r + ROW_W'(1);

  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = AW'({1'b0, in_char_code, {ROW_W{1'b0}}});
    end else begin
      rd_addr = AW'({1'b0, code_r, rd_row});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    strobe_nxt    = 1'b0;
    oaddr_nxt     = oaddr_r;
    ovalue_nxt    = ovalue_r;
    olast_nxt     = 1'b0;
    ctrl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (draw_go) begin
          ctrl.load = 1'b1;
          code_nxt  = in_char_code;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        line_nxt  = rd_data;
        row_nxt   = '0;
        col_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.step    = 1'b1;
        ctrl.row_end = (col_r == COL_LAST);
        if (pix_set) begin
          // release the held pixel; it is not the last one
          strobe_nxt    = pend_r;
          oaddr_nxt     = pend_addr_r;
          ovalue_nxt    = pixel_color;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cur_address;
        end
        col_nxt = col_r + COL_W'(1);
        if (col_r == COL_LAST) begin
          line_nxt = rd_data;
          row_nxt  = row_r + ROW_W'(1);
          if (row_r == ROW_LAST) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        strobe_nxt = pend_r;
        oaddr_nxt  = pend_addr_r;
        ovalue_nxt = pixel_color;
        olast_nxt  = 1'b1;
        pend_nxt   = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      olast_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
      olast_r  <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    line_r      <= line_nxt;
    pend_addr_r <= pend_addr_nxt;
    oaddr_r     <= oaddr_nxt;
    ovalue_r    <= ovalue_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_pixel_address = oaddr_r;
  assign out_pixel_value   = ovalue_r;
  assign out_last_write    = olast_r;

endmodule

// ----- rtl/core/bitmap_glyph_blitter.sv -----
// Top level of the bitmap glyph blitter: config registers and unit wiring.
//
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low. in_opcode selects a glyph row load or a character draw.
//   A load writes one row byte into the glyph store in that same edge, gives
//   no result and leaves busy low, so loads may follow every cycle.
//   A load or draw of a char_code at or beyond GLYPH_COUNT is dropped.
//   A valid draw raises busy while it fetches glyph row 0, scans every pixel
//   one pixel a cycle through the shared address adder and flushes the
//   held pixel; no new transaction is taken until busy falls again.
//   Result channel: one pixel write per cycle at most, out_strobe high for
//   exactly one cycle per pixel write; the receiver cannot stall. Each set
//   pixel is held one slot so the final one can carry out_last_write, which
//   shows in the first cycle after busy falls. When the first result comes
//   depends on the glyph; an empty glyph gives none at all.
//   Configuration: cfg_we with cfg_index writes row_stride or pixel_color;
//   write only while idle.
//   Reset (rst_n low, synchronous) returns to idle, drops any draw in flight
//   and restores row_stride 640 and pixel_color 0xFF0000. The glyph store
//   is not cleared; rows must be loaded before they are drawn.
`timescale 1ns / 1ps
module bitmap_glyph_blitter
  import bgb_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic [ROW_W-1:0]      in_glyph_row,
  input  logic [BITS_W-1:0]     in_row_bits,
  input  logic [COORD_W-1:0]    in_x_origin,
  input  logic [COORD_W-1:0]    in_y_origin,
  output logic                  out_strobe,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic [COLOR_W-1:0]    out_pixel_value,
  output logic                  out_last_write,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(GLYPH_COUNT * GLYPH_SIZE);
  localparam logic [CODE_W+1:0] CODE_LIMIT = (CODE_W + 2)'(GLYPH_COUNT);

  logic [STRIDE_W-1:0] row_stride_r;
  logic [COLOR_W-1:0]  pixel_color_r;
  logic                accept;
  logic                code_ok;
  logic                load_go;
  logic                draw_go;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [BITS_W-1:0]   rd_data;
  logic [ADDR_W-1:0]   cur_address;
  addr_ctrl_t          ctrl;

  // Take a transaction only when idle; drop codes beyond the store
  assign accept  = start && !busy;
  assign code_ok = ({2'b00, in_char_code} < CODE_LIMIT);
  assign load_go = accept && code_ok && (in_opcode == OP_LOAD);
  assign draw_go = accept && code_ok && (in_opcode == OP_DRAW);
  assign wr_addr = AW'({1'b0, in_char_code, in_glyph_row});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r  <= STRIDE_RESET;
      pixel_color_r <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_STRIDE:  row_stride_r  <= cfg_data[STRIDE_W-1:0];
        CFG_PIXEL_COLOR: pixel_color_r <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bgb_glyph_mem #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_go),
    .wr_addr (wr_addr),
    .wr_data (in_row_bits),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Base address is taken from the ports at the draw accept edge
  bgb_addr_unit u_addr (
    .clk           (clk),
    .ctrl          (ctrl),
    .x_origin      (in_x_origin),
    .y_origin      (in_y_origin),
    .row_stride    (row_stride_r),
    .pixel_address (cur_address)
  );

  bgb_seq #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .draw_go           (draw_go),
    .in_char_code      (in_char_code),
    .rd_data           (rd_data),
    .cur_address       (cur_address),
    .pixel_color       (pixel_color_r),
    .rd_addr           (rd_addr),
    .ctrl              (ctrl),
    .busy              (busy),
    .out_strobe        (out_strobe),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_last_write    (out_last_write)
  );

endmodule

// ----- rtl/core/bgb_checker.sv -----
// Port-level checker for the bitmap glyph blitter, bound to the top level.
`timescale 1ns / 1ps
module bgb_checker
  import bgb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_opcode,
  input logic out_strobe,
  input logic out_last_write
);

  // A draw always passes the fetch state before its first result
  a_draw_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_DRAW) |=> !out_strobe)
    else $error("result straight after draw accept");

  // A load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_LOAD) |=> !out_strobe)
    else $error("result after load");

  // The final write of a character is followed by a gap
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_write) |=> !out_strobe)
    else $error("result right after last write");

  // Outside a draw only the final write may still be shown
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !busy) |-> out_last_write)
    else $error("non-final result while idle");

endmodule

bind bitmap_glyph_blitter bgb_checker u_bgb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_opcode      (in_opcode),
  .out_strobe     (out_strobe),
  .out_last_write (out_last_write)
);

// ----- sim/tb.sv -----
// Self-checking bench for the bitmap glyph blitter: glyph loads, character draws, pixel checks.
`timescale 1ns / 1ps
module tb;
  import bgb_pkg::*;

  // One command on the input channel, with every field carried even when unused
  typedef struct {
    opcode_t            op;
    logic [CODE_W-1:0]  code;
    logic [ROW_W-1:0]   row;
    logic [BITS_W-1:0]  bits;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } glyph_cmd_t;

  // One framebuffer write as it should leave the block
  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] colour;
    logic               is_last;
  } pixel_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_opcode;
  logic [CODE_W-1:0]     in_char_code;
  logic [ROW_W-1:0]      in_glyph_row;
  logic [BITS_W-1:0]     in_row_bits;
  logic [COORD_W-1:0]    in_x_origin;
  logic [COORD_W-1:0]    in_y_origin;
  logic                  out_strobe;
  logic [ADDR_W-1:0]     out_pixel_address;
  logic [COLOR_W-1:0]    out_pixel_value;
  logic                  out_last_write;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the block: glyph rows and the two registers as last written
  logic [BITS_W-1:0]   glyph_shadow [GLYPH_COUNT_DEF][GLYPH_SIZE];
  logic [STRIDE_W-1:0] cur_stride;
  logic [COLOR_W-1:0]  cur_color;

  // Generation-side record of which glyph rows have been loaded, so that a
  // draw never touches a row that was never written
  logic [GLYPH_SIZE-1:0] rows_loaded [GLYPH_COUNT_DEF];
  int                    ready_codes [$];

  glyph_cmd_t   cmd_queue [$];
  glyph_cmd_t   live_cmd;
  pixel_write_t pending_writes [$];

  int issued_cnt;
  int accepted_cnt;
  int fail_count;
  int idle_pct;

  bitmap_glyph_blitter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .in_glyph_row      (in_glyph_row),
    .in_row_bits       (in_row_bits),
    .in_x_origin       (in_x_origin),
    .in_y_origin       (in_y_origin),
    .out_strobe        (out_strobe),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_last_write    (out_last_write),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one accepted transaction to the shadow. A load updates a glyph row;
  // a draw scans rows top to bottom, bits LSB first, and queues one write per
  // set pixel. Flag the final write of the character; an empty glyph queues
  // nothing at all.
  function automatic void plot_glyph(glyph_cmd_t c);
    int unsigned xs;
    int unsigned ys;
    int unsigned st;
    int unsigned addr;
    int          n;
    n  = 0;
    xs = 32'(c.x);
    ys = 32'(c.y);
    st = 32'(cur_stride);
    if (c.op == OP_LOAD) begin
      glyph_shadow[c.code][c.row] = c.bits;
      return;
    end
    for (int r = 0; r < GLYPH_SIZE; r++) begin
      for (int col = 0; col < ROW_PIXELS; col++) begin
        if (glyph_shadow[c.code][r][col]) begin
          // A zero stride folds every row onto the origin line; wrap to the
          // address width
          addr = (xs + col) + (ys + r) * st;
          pending_writes.push_back('{addr[ADDR_W-1:0], cur_color, 1'b0});
          n++;
        end
      end
    end
    if (n > 0) pending_writes[pending_writes.size()-1].is_last = 1'b1;
  endfunction

  // Driver: present the next queued command once the previous one is taken,
  // or hold start low and leave the input idle. Start stays high across busy, so a
  // waiting command meets every phase of a draw in progress.
  always @(posedge clk) begin : feed_proc
    logic       taken;
    glyph_cmd_t nxt;
    if (rst_n) begin
      taken = start && !busy;
      if (taken) begin
        plot_glyph(live_cmd);
        accepted_cnt++;
      end
      if (!start || taken) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt          = cmd_queue.pop_front();
          live_cmd     = nxt;
          in_opcode    <= nxt.op;
          in_char_code <= nxt.code;
          in_glyph_row <= nxt.row;
          in_row_bits  <= nxt.bits;
          in_x_origin  <= nxt.x;
          in_y_origin  <= nxt.y;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest queued pixel write
  always @(posedge clk) begin : check_proc
    pixel_write_t want;
    if (rst_n && out_strobe) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected pixel write: pixel_address %0h", out_pixel_address);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_pixel_address !== want.addr) begin
          $error("pixel_address mismatch: expected %0h, actual %0h",
                 want.addr, out_pixel_address);
          fail_count++;
        end
        if (out_pixel_value !== want.colour) begin
          $error("pixel_value mismatch: expected %0h, actual %0h",
                 want.colour, out_pixel_value);
          fail_count++;
        end
        if (out_last_write !== want.is_last) begin
          $error("last_write mismatch: expected %0b, actual %0b",
                 want.is_last, out_last_write);
          fail_count++;
        end
      end
    end
  end

  // Queue a command and note which glyphs become fully loaded
  task automatic queue_cmd(glyph_cmd_t c);
    cmd_queue.push_back(c);
    issued_cnt++;
    if (c.op == OP_LOAD && rows_loaded[c.code] != '1) begin
      rows_loaded[c.code][c.row] = 1'b1;
      if (rows_loaded[c.code] == '1) ready_codes.push_back(c.code);
    end
  endtask

  // Load one glyph row; randomise the origin fields, which a load ignores
  task automatic load_cmd(int code, int row, int bits);
    glyph_cmd_t c;
    c.op   = OP_LOAD;
    c.code = code[CODE_W-1:0];
    c.row  = row[ROW_W-1:0];
    c.bits = bits[BITS_W-1:0];
    c.x    = COORD_W'($urandom);
    c.y    = COORD_W'($urandom);
    queue_cmd(c);
  endtask

  // Draw one character; randomise the row fields, which a draw ignores
  task automatic draw_cmd(int code, int x, int y);
    glyph_cmd_t c;
    c.op   = OP_DRAW;
    c.code = code[CODE_W-1:0];
    c.row  = ROW_W'($urandom);
    c.bits = BITS_W'($urandom);
    c.x    = x[COORD_W-1:0];
    c.y    = y[COORD_W-1:0];
    queue_cmd(c);
  endtask

  // Origin biased towards the edges of the coordinate range
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 0;
    if (sel < 4) return (1 << COORD_W) - 1;
    return $urandom_range(0, (1 << COORD_W) - 1);
  endfunction

  // Row bitmap of a given density: sparse, random, solid or blank rows
  function automatic int random_row(int dens);
    int sel;
    sel = $urandom_range(0, 2);
    case (dens)
      0: return $urandom & $urandom & $urandom;
      1: return $urandom_range(0, 255);
      2: return (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      default: return 0;
    endcase
  endfunction

  // Mostly complete glyph loads followed by draws of that glyph, with stray
  // row loads and redraws of older glyphs mixed in
  task automatic run_random_phase(int n);
    int target;
    int kind;
    int code;
    int dens;
    target = issued_cnt + n;
    while (issued_cnt < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        code = $urandom_range(0, GLYPH_COUNT_DEF - 1);
        dens = $urandom_range(0, 3);
        for (int r = 0; r < GLYPH_SIZE; r++) load_cmd(code, r, random_row(dens));
        repeat ($urandom_range(1, 3)) draw_cmd(code, pick_coord(), pick_coord());
      end else if (kind < 80 || ready_codes.size() == 0) begin
        load_cmd($urandom_range(0, GLYPH_COUNT_DEF - 1), $urandom_range(0, GLYPH_SIZE - 1),
                 $urandom_range(0, 255));
      end else begin
        draw_cmd(ready_codes[$urandom_range(0, ready_codes.size() - 1)],
                 pick_coord(), pick_coord());
      end
    end
  endtask

  // Wait for every command to be taken and every write to arrive, then let
  // an empty-glyph draw run out before anything touches the registers
  task automatic settle();
    int waited;
    waited = 0;
    do @(negedge clk); while (accepted_cnt != issued_cnt);
    while (pending_writes.size() != 0 && waited < 300) begin
      @(negedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d pixel writes never arrived", pending_writes.size());
      fail_count++;
      pending_writes.delete();
    end
  endtask

  // Register write, only ever issued while the block is idle
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_STRIDE) cur_stride = val[STRIDE_W-1:0];
    else cur_color = val;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = OP_LOAD;
    in_char_code = '0;
    in_glyph_row = '0;
    in_row_bits  = '0;
    in_x_origin  = '0;
    in_y_origin  = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ROW_STRIDE;
    cfg_data     = '0;
    issued_cnt   = 0;
    accepted_cnt = 0;
    fail_count   = 0;
    idle_pct     = 0;
    cur_stride   = STRIDE_RESET;
    cur_color    = COLOR_RESET;
    for (int g = 0; g < GLYPH_COUNT_DEF; g++) rows_loaded[g] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: solid glyph at both corners, a blank glyph, and a diagonal
    // glyph on the highest code so that bit 0 and bit 7 each stand alone.
    // Reset values of both registers are in force here.
    for (int r = 0; r < GLYPH_SIZE; r++) load_cmd(0, r, 8'hFF);
    for (int r = 0; r < GLYPH_SIZE; r++) load_cmd(1, r, 8'h00);
    for (int r = 0; r < GLYPH_SIZE; r++) load_cmd(GLYPH_COUNT_DEF - 1, r, 1 << r);
    draw_cmd(0, 0, 0);
    draw_cmd(0, (1 << COORD_W) - 1, (1 << COORD_W) - 1);
    draw_cmd(1, 1023, 511);
    draw_cmd(GLYPH_COUNT_DEF - 1, (1 << COORD_W) - 1, 0);
    draw_cmd(GLYPH_COUNT_DEF - 1, 0, (1 << COORD_W) - 1);
    settle();

    // Smallest nonzero stride, black, back-to-back commands
    write_reg(CFG_ROW_STRIDE, 24'd1);
    write_reg(CFG_PIXEL_COLOR, 24'h000000);
    idle_pct = 0;
    run_random_phase(100);
    settle();

    // Widest stride, white, sparse commands; junk above the stride width
    write_reg(CFG_ROW_STRIDE, {13'($urandom_range(0, 8191)), 11'd2047});
    write_reg(CFG_PIXEL_COLOR, 24'hFFFFFF);
    idle_pct = 83;
    run_random_phase(100);
    settle();

    // Zero stride folds all rows onto one line
    write_reg(CFG_ROW_STRIDE, 24'd0);
    write_reg(CFG_PIXEL_COLOR, 24'($urandom));
    idle_pct = 7;
    run_random_phase(100);
    settle();

    // Arbitrary stride and colour; the receiver cannot stall, so no idling
    write_reg(CFG_ROW_STRIDE, 24'($urandom_range(1, 2047)));
    write_reg(CFG_PIXEL_COLOR, 24'($urandom));
    idle_pct = 0;
    run_random_phase(100);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
